/* sv/r5id_pkg.sv */
// ----------------------------------------------------------------------------
// r5id_pkg
// Shared types and codes for the RISC5 instruction decoder.
// ----------------------------------------------------------------------------
package r5id_pkg;

	// instruction formats, bits 31:30
	localparam logic [1:0] FMT_REG = 2'd0;
	localparam logic [1:0] FMT_IMM = 2'd1;
	localparam logic [1:0] FMT_MEM = 2'd2;
	localparam logic [1:0] FMT_BR  = 2'd3;

	// ALU operations used by the decode
	localparam logic [3:0] OP_MOV = 4'd0;
	localparam logic [3:0] OP_ADD = 4'd8;
	localparam logic [3:0] OP_SUB = 4'd9;
	localparam logic [3:0] OP_MUL = 4'd10;

	// modifiers
	localparam logic [2:0] MOD_NONE  = 3'd0;
	localparam logic [2:0] MOD_CARRY = 3'd1;
	localparam logic [2:0] MOD_UMUL  = 3'd2;
	localparam logic [2:0] MOD_H     = 3'd3;
	localparam logic [2:0] MOD_FLAGS = 3'd4;

	// branch kinds
	localparam logic [2:0] BK_BR_REG   = 3'd0;
	localparam logic [2:0] BK_RTI      = 3'd1;
	localparam logic [2:0] BK_DI       = 3'd2;
	localparam logic [2:0] BK_EI       = 3'd3;
	localparam logic [2:0] BK_UNDEF    = 3'd4;
	localparam logic [2:0] BK_CALL_REG = 3'd5;
	localparam logic [2:0] BK_BR_REL   = 3'd6;
	localparam logic [2:0] BK_CALL_REL = 3'd7;

	// register-branch sub forms, bits 5:4
	localparam logic [1:0] SUB_BR   = 2'd0;
	localparam logic [1:0] SUB_RTI  = 2'd1;
	localparam logic [1:0] SUB_INTR = 2'd2;
	localparam logic [1:0] SUB_UNDF = 2'd3;

	typedef struct packed {
		logic [1:0]  format;
		logic [3:0]  reg_a;
		logic [3:0]  reg_b;
		logic [3:0]  reg_c;
		logic [3:0]  alu_op;
		logic [2:0]  modifier;
		logic        mem_store;
		logic        mem_byte;
		logic [2:0]  branch_kind;
		logic [3:0]  cond;
		logic [31:0] operand_value;
		logic [31:0] branch_target;
	} result_t;

endpackage

/* sv/r5id_decode.sv */
// ----------------------------------------------------------------------------
// r5id_decode
// Combinational field decode of one instruction word and its address.
// ----------------------------------------------------------------------------
module r5id_decode (
	input  logic [31:0]      instr,
	input  logic [31:0]      pc,
	output r5id_pkg::result_t res
);

	logic [1:0]  fmt;
	logic        u;
	logic        v;
	logic [3:0]  fa;
	logic [3:0]  fb;
	logic [3:0]  fop;
	logic [3:0]  fc;
	logic [31:0] imm;
	logic [29:0] tgt_word;

	assign fmt = instr[31:30];
	assign u   = instr[29];
	assign v   = instr[28];
	assign fa  = instr[27:24];
	assign fb  = instr[23:20];
	assign fop = instr[19:16];
	assign fc  = instr[3:0];

	// immediate filled with v (ones when v, else zeros), MOV with u moves it to the upper half
	always_comb begin
		imm = {(v ? 16'hFFFF : 16'h0000), instr[15:0]};
		if (fop == r5id_pkg::OP_MOV && u)
			imm = {imm[15:0], 16'h0000};
	end

	// word target: (pc>>2) + 1 + sign-extended offset, modulo 2^30 words
	assign tgt_word = pc[31:2] + 30'd1 + {{6{instr[23]}}, instr[23:0]};

	always_comb begin
		res        = '0;
		res.format = fmt;
		unique case (fmt) inside
			r5id_pkg::FMT_REG, r5id_pkg::FMT_IMM: begin
				res.reg_a  = fa;
				res.alu_op = fop;
				if (fop == r5id_pkg::OP_MOV) begin
					if (fmt == r5id_pkg::FMT_REG) begin
						if (!u)
							res.reg_c = fc;
						else
							res.modifier = v ? r5id_pkg::MOD_FLAGS : r5id_pkg::MOD_H;
					end
				end else begin
					res.reg_b = fb;
					if (fmt == r5id_pkg::FMT_REG)
						res.reg_c = fc;
					if (u) begin
						unique case (fop) inside
							r5id_pkg::OP_ADD, r5id_pkg::OP_SUB:
								res.modifier = r5id_pkg::MOD_CARRY;
							r5id_pkg::OP_MUL:
								res.modifier = r5id_pkg::MOD_UMUL;
							default:
								res.modifier = r5id_pkg::MOD_NONE;
						endcase
					end
				end
				if (fmt == r5id_pkg::FMT_IMM)
					res.operand_value = imm;
			end
			r5id_pkg::FMT_MEM: begin
				res.reg_a         = fa;
				res.reg_b         = fb;
				res.mem_store     = u;
				res.mem_byte      = v;
				res.operand_value = {{12{instr[19]}}, instr[19:0]};
			end
			default: begin
				if (!u) begin
					if (!v) begin
						unique case (instr[5:4])
							r5id_pkg::SUB_BR: begin
								res.branch_kind = r5id_pkg::BK_BR_REG;
								res.reg_c       = fc;
								res.cond        = fa;
							end
							r5id_pkg::SUB_RTI:  res.branch_kind = r5id_pkg::BK_RTI;
							r5id_pkg::SUB_INTR: res.branch_kind = instr[0] ? r5id_pkg::BK_EI
							                                               : r5id_pkg::BK_DI;
							default:            res.branch_kind = r5id_pkg::BK_UNDEF;
						endcase
					end else begin
						res.branch_kind = r5id_pkg::BK_CALL_REG;
						res.reg_c       = fc;
						res.cond        = fa;
					end
				end else begin
					res.branch_kind   = v ? r5id_pkg::BK_CALL_REL : r5id_pkg::BK_BR_REL;
					res.cond          = fa;
					res.branch_target = {tgt_word, 2'b00};
				end
			end
		endcase
	end

endmodule

/* sv/risc5_instruction_decoder_unit.sv */
// ----------------------------------------------------------------------------
// risc5_instruction_decoder_unit
// Two-stage RISC5 instruction decoder: input register, decode, result register.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction | beat
//  --------+--------------------------------+-----------+--------------------------
//  in      | in_valid in_ready instr pc     | sink      | one instruction word
//  out     | out_valid out_ready format ... | source    | one decoded instruction
//
//  One beat per cycle sustained while out is ready; a beat passes the input register, then the result register.
//  The decode sits between the input register and the result register.
//  Reset clears both stage valid bits; no beat is shown after reset.
//  A stall on out holds the result; in keeps taking beats while a stage is free.
// ----------------------------------------------------------------------------
module risc5_instruction_decoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] instr,
	input  logic [31:0] pc,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  format,
	output logic [3:0]  reg_a,
	output logic [3:0]  reg_b,
	output logic [3:0]  reg_c,
	output logic [3:0]  alu_op,
	output logic [2:0]  modifier,
	output logic        mem_store,
	output logic        mem_byte,
	output logic [2:0]  branch_kind,
	output logic [3:0]  cond,
	output logic [31:0] operand_value,
	output logic [31:0] branch_target
);

	logic              valid_s1;
	logic [31:0]       instr_s1;
	logic [31:0]       pc_s1;
	logic              valid_s2;
	r5id_pkg::result_t res_s2;
	r5id_pkg::result_t res_d;
	logic              adv_s2;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			instr_s1 <= instr;
			pc_s1    <= pc;
		end
		if (adv_s2 && valid_s1)
			res_s2 <= res_d;
	end

	r5id_decode u_decode (
		.instr (instr_s1),
		.pc    (pc_s1),
		.res   (res_d)
	);

	assign out_valid     = valid_s2;
	assign format        = res_s2.format;
	assign reg_a         = res_s2.reg_a;
	assign reg_b         = res_s2.reg_b;
	assign reg_c         = res_s2.reg_c;
	assign alu_op        = res_s2.alu_op;
	assign modifier      = res_s2.modifier;
	assign mem_store     = res_s2.mem_store;
	assign mem_byte      = res_s2.mem_byte;
	assign branch_kind   = res_s2.branch_kind;
	assign cond          = res_s2.cond;
	assign operand_value = res_s2.operand_value;
	assign branch_target = res_s2.branch_target;

	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 out_ready |=> out_valid)
		else $error("accepted beat did not reach output");

	a_br_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format != r5id_pkg::FMT_BR |-> branch_kind == '0 && branch_target == '0)
		else $error("branch fields set outside branch format");

	a_mem_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && format != r5id_pkg::FMT_MEM |-> !mem_store && !mem_byte)
		else $error("memory fields set outside memory format");

endmodule
